FILE: rtl/core/efcs_pkg.sv
// Shared definitions for the ellipse fill column span core.
// Depends on nothing; imported by efcs_front, efcs_back and the top core.
`default_nettype none

package efcs_pkg;

  localparam int COORD_WIDTH_DEF = 10;
  localparam int COLOR_WIDTH     = 16;
  localparam int QUEUE_DEPTH     = 2;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } back_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/efcs_queue.sv
// Small register FIFO that parts the classifying front from the row search.
// Depends on nothing; width and depth are parameters.
`default_nettype none

module efcs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/efcs_front.sv
// Front end: accepts requests, derives radii and column distance, classifies
// trivially empty columns and forms the search constants in three stages.
// Depends on efcs_pkg; feeds efcs_queue.
`default_nettype none

module efcs_front #(
  parameter int COORD_WIDTH = efcs_pkg::COORD_WIDTH_DEF,
  parameter int JOB_WIDTH   = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [COORD_WIDTH-1:0]             center_x,
  input  wire logic [COORD_WIDTH-1:0]             center_y,
  input  wire logic [COORD_WIDTH-1:0]             box_width,
  input  wire logic [COORD_WIDTH-1:0]             box_height,
  input  wire logic signed [COORD_WIDTH+1:0]      column,
  input  wire logic [efcs_pkg::COLOR_WIDTH-1:0]   pixel_color,
  output logic                                    job_push,
  output logic [JOB_WIDTH-1:0]                    job_data,
  input  wire logic                               job_full
);
  import efcs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int WW   = COORD_WIDTH + 2;
  localparam int RW   = COORD_WIDTH - 1;
  localparam int SQ_W = 2 * RW;
  localparam int PW   = 4 * RW;

  logic adv;
  logic take;

  logic signed [CW+2:0] diff;
  logic [CW+2:0]        neg_diff;
  logic [CW+1:0]        adx_full;
  logic [RW-1:0]        rx_in;
  logic [RW-1:0]        ry_in;
  logic                 far;

  logic                   s1_valid;
  logic [RW-1:0]          s1_rx;
  logic [RW-1:0]          s1_ry;
  logic [RW-1:0]          s1_adx;
  logic                   s1_skip;
  logic [CW-1:0]          s1_cy;
  logic [CW-1:0]          s1_h;
  logic [WW-1:0]          s1_col;
  logic [COLOR_WIDTH-1:0] s1_color;

  logic                   s2_valid;
  logic [RW-1:0]          s2_ry;
  logic [SQ_W-1:0]        s2_rx2;
  logic [SQ_W-1:0]        s2_ry2;
  logic [SQ_W-1:0]        s2_ax2;
  logic                   s2_skip;
  logic [CW-1:0]          s2_cy;
  logic [CW-1:0]          s2_h;
  logic [WW-1:0]          s2_col;
  logic [COLOR_WIDTH-1:0] s2_color;

  logic                   s3_valid;
  logic [RW-1:0]          s3_ry;
  logic [SQ_W-1:0]        s3_rx2;
  logic [PW-1:0]          s3_rhs;
  logic [PW-1:0]          s3_t;
  logic [PW-1:0]          s3_p;
  logic                   s3_skip;
  logic [CW-1:0]          s3_cy;
  logic [CW-1:0]          s3_h;
  logic [WW-1:0]          s3_col;
  logic [COLOR_WIDTH-1:0] s3_color;

  logic [PW-1:0] lim;
  logic [PW-1:0] step0;

  assign adv      = !s3_valid || !job_full;
  assign full     = !adv;
  assign take     = push && adv;
  assign job_push = s3_valid && !job_full;

  assign diff     = $signed({3'b000, center_x}) - $signed({column[WW-1], column});
  assign neg_diff = -diff;
  assign adx_full = diff[CW+2] ? neg_diff[CW+1:0] : diff[CW+1:0];
  assign rx_in    = box_width[CW-1:1];
  assign ry_in    = box_height[CW-1:1];
  assign far      = adx_full >= {3'b000, rx_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rx    <= rx_in;
      s1_ry    <= ry_in;
      s1_adx   <= adx_full[RW-1:0];
      s1_skip  <= far || (rx_in == '0) || (ry_in == '0);
      s1_cy    <= center_y;
      s1_h     <= box_height;
      s1_col   <= column;
      s1_color <= pixel_color;

      s2_ry    <= s1_ry;
      s2_rx2   <= SQ_W'(s1_rx) * SQ_W'(s1_rx);
      s2_ry2   <= SQ_W'(s1_ry) * SQ_W'(s1_ry);
      s2_ax2   <= SQ_W'(s1_adx) * SQ_W'(s1_adx);
      s2_skip  <= s1_skip;
      s2_cy    <= s1_cy;
      s2_h     <= s1_h;
      s2_col   <= s1_col;
      s2_color <= s1_color;

      s3_ry    <= s2_ry;
      s3_rx2   <= s2_rx2;
      s3_rhs   <= PW'(s2_rx2) * PW'(s2_ry2);
      s3_t     <= PW'(s2_ax2) * PW'(s2_ry2);
      s3_p     <= PW'(s2_rx2) * PW'(s2_ry);
      s3_skip  <= s2_skip;
      s3_cy    <= s2_cy;
      s3_h     <= s2_h;
      s3_col   <= s2_col;
      s3_color <= s2_color;
    end
  end

  assign lim   = s3_rhs - s3_t;
  assign step0 = {s3_p[PW-2:0], 1'b0} - PW'(s3_rx2);

  assign job_data = {s3_rx2, s3_rhs, lim, step0, s3_ry, s3_skip,
                     s3_cy, s3_h, s3_col, s3_color};

endmodule

`default_nettype wire

FILE: rtl/core/efcs_back.sv
// Back end: walks rows from the top of the bounding box toward the center,
// one row per cycle by difference updates, and holds the result register.
// Depends on efcs_pkg; drains efcs_queue.
`default_nettype none

module efcs_back #(
  parameter int COORD_WIDTH = efcs_pkg::COORD_WIDTH_DEF,
  parameter int JOB_WIDTH   = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic [JOB_WIDTH-1:0]              job_data,
  input  wire logic                              job_empty,
  output logic                                   job_pop,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   span_valid,
  output logic signed [COORD_WIDTH+1:0]          span_column,
  output logic signed [COORD_WIDTH+1:0]          span_top,
  output logic [COORD_WIDTH-1:0]                 span_length,
  output logic [efcs_pkg::COLOR_WIDTH-1:0]       span_color
);
  import efcs_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int WW   = COORD_WIDTH + 2;
  localparam int RW   = COORD_WIDTH - 1;
  localparam int SQ_W = 2 * RW;
  localparam int PW   = 4 * RW;

  logic [SQ_W-1:0]        j_rx2;
  logic [PW-1:0]          j_sq0;
  logic [PW-1:0]          j_lim;
  logic [PW-1:0]          j_step0;
  logic [RW-1:0]          j_ry;
  logic                   j_skip;
  logic [CW-1:0]          j_cy;
  logic [CW-1:0]          j_h;
  logic [WW-1:0]          j_col;
  logic [COLOR_WIDTH-1:0] j_color;

  back_state_t state;
  back_state_t state_next;

  logic [PW-1:0]          sq;
  logic [PW-1:0]          lim;
  logic [PW-1:0]          step;
  logic [SQ_W-1:0]        rx2;
  logic [RW-1:0]          ady;
  logic [RW-1:0]          ry;
  logic                   skip;
  logic [CW-1:0]          cy;
  logic [CW-1:0]          h;
  logic [WW-1:0]          col;
  logic [COLOR_WIDTH-1:0] color;
  logic                   out_valid;

  logic          hit;
  logic          last;
  logic          load;
  logic          advance;
  logic          finish;
  logic [RW-1:0] off;
  logic [WW-1:0] top_calc;
  logic [CW-1:0] len_calc;

  assign {j_rx2, j_sq0, j_lim, j_step0, j_ry, j_skip,
          j_cy, j_h, j_col, j_color} = job_data;

  assign hit      = !skip && (sq < lim);
  assign last     = skip || hit || (ady == '0);
  assign off      = ry - ady;
  assign top_calc = {2'b00, cy} - {3'b000, ady};
  assign len_calc = h - {off, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    job_pop    = 1'b0;
    load       = 1'b0;
    advance    = 1'b0;
    finish     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!job_empty) begin
          job_pop    = 1'b1;
          load       = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!last) begin
          advance = 1'b1;
        end else if (!out_valid || pop) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sq    <= j_sq0;
      lim   <= j_lim;
      step  <= j_step0;
      rx2   <= j_rx2;
      ady   <= j_ry;
      ry    <= j_ry;
      skip  <= j_skip;
      cy    <= j_cy;
      h     <= j_h;
      col   <= j_col;
      color <= j_color;
    end else if (advance) begin
      sq   <= sq - step;
      step <= step - PW'({rx2, 1'b0});
      ady  <= ady - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      span_valid  <= hit;
      span_column <= col;
      span_top    <= hit ? top_calc : '0;
      span_length <= hit ? len_calc : '0;
      span_color  <= color;
    end
  end

  assign empty = !out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/ellipse_fill_column_span_core.sv
// Filled-ellipse column span core: for one ellipse and one screen column, finds
// the top row inside the ellipse and the span length. Requests enter through a
// three-stage front (radii, squares, products), wait in a two-entry queue, and
// are searched by the back end one row per cycle from the top of the bounding
// box toward the center, using difference updates of the quadratic test. The
// front and queue keep taking requests while a search runs, so the sustained
// rate is set by that search loop; columns outside the ellipse or with zero
// radii are flagged in the front and finish without walking rows. Results
// leave through a register that holds until popped while the next search runs.
// Depends on efcs_pkg, efcs_front, efcs_queue and efcs_back.
`default_nettype none

module ellipse_fill_column_span_core #(
  parameter int COORD_WIDTH = efcs_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              push,
  output logic                                   full,
  input  wire logic [COORD_WIDTH-1:0]            center_x,
  input  wire logic [COORD_WIDTH-1:0]            center_y,
  input  wire logic [COORD_WIDTH-1:0]            box_width,
  input  wire logic [COORD_WIDTH-1:0]            box_height,
  input  wire logic signed [COORD_WIDTH+1:0]     column,
  input  wire logic [efcs_pkg::COLOR_WIDTH-1:0]  pixel_color,
  output logic                                   empty,
  input  wire logic                              pop,
  output logic                                   span_valid,
  output logic signed [COORD_WIDTH+1:0]          span_column,
  output logic signed [COORD_WIDTH+1:0]          span_top,
  output logic [COORD_WIDTH-1:0]                 span_length,
  output logic [efcs_pkg::COLOR_WIDTH-1:0]       span_color
);
  import efcs_pkg::*;

  localparam int RW        = COORD_WIDTH - 1;
  localparam int SQ_W      = 2 * RW;
  localparam int PW        = 4 * RW;
  localparam int JOB_WIDTH = SQ_W + 3 * PW + RW + 1 + 2 * COORD_WIDTH
                             + (COORD_WIDTH + 2) + COLOR_WIDTH;

  logic                 job_push;
  logic [JOB_WIDTH-1:0] job_wdata;
  logic                 job_full;
  logic                 job_pop;
  logic [JOB_WIDTH-1:0] job_rdata;
  logic                 job_empty;

  efcs_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .JOB_WIDTH   (JOB_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .center_x    (center_x),
    .center_y    (center_y),
    .box_width   (box_width),
    .box_height  (box_height),
    .column      (column),
    .pixel_color (pixel_color),
    .job_push    (job_push),
    .job_data    (job_wdata),
    .job_full    (job_full)
  );

  efcs_queue #(
    .WIDTH (JOB_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_wdata),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (job_rdata),
    .empty   (job_empty)
  );

  efcs_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .JOB_WIDTH   (JOB_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .job_data    (job_rdata),
    .job_empty   (job_empty),
    .job_pop     (job_pop),
    .empty       (empty),
    .pop         (pop),
    .span_valid  (span_valid),
    .span_column (span_column),
    .span_top    (span_top),
    .span_length (span_length),
    .span_color  (span_color)
  );

endmodule

`default_nettype wire
